// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RCM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RCM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rcm_pkg.sv -----
package rcm_pkg;

  localparam int PIX_W  = 16;
  localparam int GAIN_W = 16;
  localparam int ROW_W  = 48;
  localparam int OFS_W  = 32;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int PROD_W = 33;
  localparam int SUM_W  = 36;

  localparam logic [PIX_W-1:0] MAX_NARROW = 16'h00FF;
  localparam logic [PIX_W-1:0] MAX_WIDE   = 16'hFFFF;

  localparam logic [ROW_W-1:0] GAINS_RED_RESET   = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0] GAINS_GREEN_RESET = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] GAINS_BLUE_RESET  = 48'h1000_0000_0000;
  localparam logic [OFS_W-1:0] OFFSET_RESET      = 32'h0000_0000;

  typedef enum logic [2:0] {
    REG_GAINS_RED,
    REG_GAINS_GREEN,
    REG_GAINS_BLUE,
    REG_OFFSET_RED,
    REG_OFFSET_GREEN,
    REG_OFFSET_BLUE,
    REG_WIDE_PIXELS
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0] gains;
    logic [OFS_W-1:0] offset;
  } row_cfg_t;

  typedef struct packed {
    logic prod;
    logic sum;
    logic rnd;
  } stage_en_t;

endpackage

// ----- rtl/rcm_in_if.sv -----
interface rcm_in_if;
  logic                     valid;
  logic                     ready;
  logic [rcm_pkg::PIX_W-1:0] red_in;
  logic [rcm_pkg::PIX_W-1:0] green_in;
  logic [rcm_pkg::PIX_W-1:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ----- rtl/rcm_out_if.sv -----
interface rcm_out_if;
  logic                     valid;
  logic                     ready;
  logic [rcm_pkg::PIX_W-1:0] red_out;
  logic [rcm_pkg::PIX_W-1:0] green_out;
  logic [rcm_pkg::PIX_W-1:0] blue_out;

  modport source(output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

// ----- rtl/rgb_color_matrix_3x4_unit.sv -----
// Stages are input, multiply, sum, round/clamp; the last drives the output.
// Throughput: one pixel per cycle while the output is not stalled.
// Output stalls hold full stages with no empty stage after them; empty ones fill.
// Reset clears all stage valid bits and loads the identity matrix, zero offsets
// and 8-bit mode.
`include "assert_macros.svh"

module rgb_color_matrix_3x4_unit #(
  parameter int FRACTION_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  rcm_in_if.sink                     pixel,
  rcm_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcm_pkg::ADDR_W-1:0] paddr,
  input  logic [rcm_pkg::DATA_W-1:0] pwdata,
  output logic [rcm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [rcm_pkg::ROW_W-1:0] gains_red;
  logic [rcm_pkg::ROW_W-1:0] gains_green;
  logic [rcm_pkg::ROW_W-1:0] gains_blue;
  logic [rcm_pkg::OFS_W-1:0] offset_red;
  logic [rcm_pkg::OFS_W-1:0] offset_green;
  logic [rcm_pkg::OFS_W-1:0] offset_blue;
  logic                      wide;
  logic                      cfg_write;
  rcm_pkg::reg_idx_t         reg_idx;

  logic                      v0;
  logic                      v1;
  logic                      v2;
  logic                      v3;
  logic                      en0;
  rcm_pkg::stage_en_t        en;
  logic [rcm_pkg::PIX_W-1:0] px_r;
  logic [rcm_pkg::PIX_W-1:0] px_g;
  logic [rcm_pkg::PIX_W-1:0] px_b;
  logic [rcm_pkg::PIX_W-1:0] in_mask;
  rcm_pkg::row_cfg_t         cfg_red;
  rcm_pkg::row_cfg_t         cfg_green;
  rcm_pkg::row_cfg_t         cfg_blue;
  logic                      out_narrow;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = rcm_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gains_red    <= rcm_pkg::GAINS_RED_RESET;
      gains_green  <= rcm_pkg::GAINS_GREEN_RESET;
      gains_blue   <= rcm_pkg::GAINS_BLUE_RESET;
      offset_red   <= rcm_pkg::OFFSET_RESET;
      offset_green <= rcm_pkg::OFFSET_RESET;
      offset_blue  <= rcm_pkg::OFFSET_RESET;
      wide         <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        rcm_pkg::REG_GAINS_RED:    gains_red    <= pwdata[rcm_pkg::ROW_W-1:0];
        rcm_pkg::REG_GAINS_GREEN:  gains_green  <= pwdata[rcm_pkg::ROW_W-1:0];
        rcm_pkg::REG_GAINS_BLUE:   gains_blue   <= pwdata[rcm_pkg::ROW_W-1:0];
        rcm_pkg::REG_OFFSET_RED:   offset_red   <= pwdata[rcm_pkg::OFS_W-1:0];
        rcm_pkg::REG_OFFSET_GREEN: offset_green <= pwdata[rcm_pkg::OFS_W-1:0];
        rcm_pkg::REG_OFFSET_BLUE:  offset_blue  <= pwdata[rcm_pkg::OFS_W-1:0];
        rcm_pkg::REG_WIDE_PIXELS:  wide         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rcm_pkg::REG_GAINS_RED:    prdata = rcm_pkg::DATA_W'(gains_red);
      rcm_pkg::REG_GAINS_GREEN:  prdata = rcm_pkg::DATA_W'(gains_green);
      rcm_pkg::REG_GAINS_BLUE:   prdata = rcm_pkg::DATA_W'(gains_blue);
      rcm_pkg::REG_OFFSET_RED:   prdata = rcm_pkg::DATA_W'(offset_red);
      rcm_pkg::REG_OFFSET_GREEN: prdata = rcm_pkg::DATA_W'(offset_green);
      rcm_pkg::REG_OFFSET_BLUE:  prdata = rcm_pkg::DATA_W'(offset_blue);
      rcm_pkg::REG_WIDE_PIXELS:  prdata = rcm_pkg::DATA_W'(wide);
      default:                   prdata = '0;
    endcase
  end

  // advance a stage when it is empty or the next one moves
  assign en.rnd      = !v3 || result.ready;
  assign en.sum      = !v2 || en.rnd;
  assign en.prod     = !v1 || en.sum;
  assign en0         = !v0 || en.prod;
  assign pixel.ready = en0;
  assign in_mask     = wide ? rcm_pkg::MAX_WIDE : rcm_pkg::MAX_NARROW;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= pixel.valid;
      end
      if (en.prod) begin
        v1 <= v0;
      end
      if (en.sum) begin
        v2 <= v1;
      end
      if (en.rnd) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && pixel.valid) begin
      px_r <= pixel.red_in & in_mask;
      px_g <= pixel.green_in & in_mask;
      px_b <= pixel.blue_in & in_mask;
    end
  end

  assign cfg_red   = '{gains: gains_red,   offset: offset_red};
  assign cfg_green = '{gains: gains_green, offset: offset_green};
  assign cfg_blue  = '{gains: gains_blue,  offset: offset_blue};

  rcm_channel #(.FRACTION_BITS(FRACTION_BITS)) u_red (
    .clk   (clk),
    .en    (en),
    .px_r  (px_r),
    .px_g  (px_g),
    .px_b  (px_b),
    .cfg   (cfg_red),
    .wide  (wide),
    .value (result.red_out)
  );

  rcm_channel #(.FRACTION_BITS(FRACTION_BITS)) u_green (
    .clk   (clk),
    .en    (en),
    .px_r  (px_r),
    .px_g  (px_g),
    .px_b  (px_b),
    .cfg   (cfg_green),
    .wide  (wide),
    .value (result.green_out)
  );

  rcm_channel #(.FRACTION_BITS(FRACTION_BITS)) u_blue (
    .clk   (clk),
    .en    (en),
    .px_r  (px_r),
    .px_g  (px_g),
    .px_b  (px_b),
    .cfg   (cfg_blue),
    .wide  (wide),
    .value (result.blue_out)
  );

  assign result.valid = v3;

  assign out_narrow = (result.red_out | result.green_out | result.blue_out) <= rcm_pkg::MAX_NARROW;

  `RCM_ASSERT_ALWAYS(a_rst_empty, rst |=> !v0 && !v1 && !v2 && !v3, "pipeline not empty after reset")
  `RCM_ASSERT(a_sum_hold, v2 && !en.sum |=> v2, "sum stage dropped a request")
  `RCM_ASSERT(a_prod_move, v0 && en.prod |=> v1, "multiply stage lost a request")
  `RCM_ASSERT(a_narrow_clamp, result.valid && !wide |-> out_narrow, "8-bit result above 255")

endmodule

// ----- rtl/rcm_channel.sv -----
module rcm_channel #(
  parameter int FRACTION_BITS = 12
) (
  input  logic                      clk,
  input  rcm_pkg::stage_en_t        en,
  input  logic [rcm_pkg::PIX_W-1:0] px_r,
  input  logic [rcm_pkg::PIX_W-1:0] px_g,
  input  logic [rcm_pkg::PIX_W-1:0] px_b,
  input  rcm_pkg::row_cfg_t         cfg,
  input  logic                      wide,
  output logic [rcm_pkg::PIX_W-1:0] value
);

  localparam int SUM_W = rcm_pkg::SUM_W;
  localparam logic [FRACTION_BITS-1:0] HALF = {1'b1, {(FRACTION_BITS-1){1'b0}}};

  logic signed [rcm_pkg::GAIN_W-1:0] g_r;
  logic signed [rcm_pkg::GAIN_W-1:0] g_g;
  logic signed [rcm_pkg::GAIN_W-1:0] g_b;
  logic signed [rcm_pkg::OFS_W-1:0]  ofs;
  logic signed [rcm_pkg::PROD_W-1:0] prod_r;
  logic signed [rcm_pkg::PROD_W-1:0] prod_g;
  logic signed [rcm_pkg::PROD_W-1:0] prod_b;
  logic signed [SUM_W-1:0]           sum;
  logic signed [SUM_W-1:0]           q;
  logic [FRACTION_BITS-1:0]          rem;
  logic                              up;
  logic [SUM_W-1:0]                  qr;
  logic [rcm_pkg::PIX_W-1:0]         maxv;
  logic [rcm_pkg::PIX_W-1:0]         value_next;

  assign g_r = cfg.gains[15:0];
  assign g_g = cfg.gains[31:16];
  assign g_b = cfg.gains[47:32];
  assign ofs = cfg.offset;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      prod_r <= $signed({1'b0, px_r}) * g_r;
      prod_g <= $signed({1'b0, px_g}) * g_g;
      prod_b <= $signed({1'b0, px_b}) * g_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      sum <= SUM_W'(prod_r) + SUM_W'(prod_g) + SUM_W'(prod_b) + SUM_W'(ofs);
    end
  end

  always_comb begin
    q    = sum >>> FRACTION_BITS;
    rem  = sum[FRACTION_BITS-1:0];
    up   = (rem > HALF) || ((rem == HALF) && q[0]);
    qr   = q + SUM_W'(up);
    maxv = wide ? rcm_pkg::MAX_WIDE : rcm_pkg::MAX_NARROW;
    if (qr[SUM_W-1]) begin
      value_next = '0;
    end else if (qr > SUM_W'(maxv)) begin
      value_next = maxv;
    end else begin
      value_next = qr[rcm_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      value <= value_next;
    end
  end

endmodule
